[hw/rtl/dhcplt_pkg.sv]
`default_nettype none

package dhcplt_pkg;

  localparam int LEASE_SLOTS_DEF = 8;

  localparam int MAC_W    = 48;
  localparam int TIME_W   = 32;
  localparam int OCTET_W  = 8;
  localparam int ACTION_W = 2;
  localparam int STATUS_W = 2;
  localparam int SLOT_W   = 3;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 32;

  localparam int S_TDATA_W = 96;
  localparam int M_TDATA_W = 16;

  // message kinds
  localparam logic [ACTION_W-1:0] ACT_DISCOVER = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_REQUEST  = 2'd1;

  // reply codes
  localparam logic [STATUS_W-1:0] REPLY_OFFER  = 2'd0;
  localparam logic [STATUS_W-1:0] REPLY_ACK    = 2'd1;
  localparam logic [STATUS_W-1:0] REPLY_IGNORE = 2'd2;

  // register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_ADDRESS_BASE = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_OFFER_HOLD   = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_LEASE_TIME   = 2'd2;

  localparam logic [OCTET_W-1:0] ADDRESS_BASE_RST = 8'd16;
  localparam logic [TIME_W-1:0]  OFFER_HOLD_RST   = 32'd60000;
  localparam logic [TIME_W-1:0]  LEASE_TIME_RST   = 32'd86400000;

  typedef struct packed {
    logic [MAC_W-1:0]  mac;
    logic [TIME_W-1:0] expiry;
  } lease_entry_t;

endpackage

`default_nettype wire

[hw/rtl/dhcplt_lease_mem.sv]
`default_nettype none

module dhcplt_lease_mem #(
  parameter int SLOTS = dhcplt_pkg::LEASE_SLOTS_DEF,
  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     rd_en,
  input  wire logic [IDX_W-1:0]         rd_addr,
  output dhcplt_pkg::lease_entry_t      rd_data,
  input  wire logic                     wr_en,
  input  wire logic [IDX_W-1:0]         wr_addr,
  input  wire dhcplt_pkg::lease_entry_t wr_data
);
  import dhcplt_pkg::*;

  lease_entry_t mem [SLOTS];
  logic [SLOTS-1:0] valid;
  lease_entry_t rd_raw;
  logic         rd_valid;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_raw <= mem[rd_addr];
    end
  end

  // entries never written read as an unused slot
  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid <= valid[rd_addr];
      end
    end
  end

  assign rd_data = rd_valid ? rd_raw : '0;

endmodule

`default_nettype wire

[hw/rtl/dhcp_lease_table_engine.sv]
// DHCP lease table engine.
// Input channel s_*: one decoded client message per item (kind in s_tuser, MAC,
// requested octet and current time in s_tdata). Output channel m_*: one reply
// per item (reply code in m_tuser, slot and assigned octet in m_tdata).
// The lease table sits in a registered-read memory. Each item scans the slots
// one read per cycle, picks the MAC hit, else the first unused or expired slot,
// else the earliest expiry, then writes the slot back unless a request names
// another octet. A MAC hit ends the scan early, and a kind that is neither
// discover nor request skips the scan. One item is in work at a time: s_tready
// stays low until its reply has moved into the output register.
// The output register parts the channels: a new item is taken while a reply
// waits on m_tready; a second reply waits inside, with s_tready low, until the
// register frees.
// Config writes (cfg_we, cfg_addr, cfg_data) take effect at once and must be
// made while idle by the user; the block does not enforce it. Reset returns
// registers to defaults and marks every slot unused through per-slot valid
// bits, with no clearing pass.
`default_nettype none

module dhcp_lease_table_engine #(
  parameter int LEASE_SLOTS = dhcplt_pkg::LEASE_SLOTS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  // client_mac[47:0], has_requested_ip[48], requested_octet[56:49], now_ms[88:57]
  input  wire logic [dhcplt_pkg::S_TDATA_W-1:0] s_tdata,
  // action[1:0]
  input  wire logic [dhcplt_pkg::ACTION_W-1:0]  s_tuser,
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  // slot_index[2:0], offered_octet[10:3]
  output logic [dhcplt_pkg::M_TDATA_W-1:0]      m_tdata,
  // reply_status[1:0]
  output logic [dhcplt_pkg::STATUS_W-1:0]       m_tuser,
  input  wire logic                             cfg_we,
  input  wire logic [dhcplt_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [dhcplt_pkg::CFG_DATA_W-1:0] cfg_data
);
  import dhcplt_pkg::*;

  localparam int IDX_W = (LEASE_SLOTS > 1) ? $clog2(LEASE_SLOTS) : 1;
  localparam int CNT_W = $clog2(LEASE_SLOTS + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_RESULT
  } state_t;

  state_t state;

  logic [OCTET_W-1:0] address_base;
  logic [TIME_W-1:0]  offer_hold_ms;
  logic [TIME_W-1:0]  lease_time_ms;

  // item registers
  logic [ACTION_W-1:0] item_action;
  logic [MAC_W-1:0]    item_mac;
  logic                item_has_req;
  logic [OCTET_W-1:0]  item_req_octet;
  logic [TIME_W-1:0]   item_now;

  // scan state
  logic [CNT_W-1:0]  issue_cnt;
  logic              eval_valid;
  logic [IDX_W-1:0]  eval_idx;
  logic              have_free;
  logic [IDX_W-1:0]  free_slot;
  logic [IDX_W-1:0]  oldest;
  logic [TIME_W-1:0] oldest_exp;
  logic [IDX_W-1:0]  sel;

  // pending reply
  logic [STATUS_W-1:0] res_status;
  logic [SLOT_W-1:0]   res_slot;
  logic [OCTET_W-1:0]  res_octet;

  logic [STATUS_W-1:0] out_status;
  logic [SLOT_W-1:0]   out_slot;
  logic [OCTET_W-1:0]  out_octet;

  lease_entry_t rd_data;
  lease_entry_t wr_data;
  logic         rd_en;
  logic         wr_en;

  // entry evaluation
  logic [TIME_W-1:0] diff_now;
  logic [TIME_W-1:0] diff_old;
  logic              unused;
  logic              expired;
  logic              hit;
  logic              free_here;
  logic              have_free_upd;
  logic [IDX_W-1:0]  free_upd;
  logic [IDX_W-1:0]  oldest_upd;
  logic [TIME_W-1:0] oldest_exp_upd;
  logic              last_eval;

  // decision
  logic [IDX_W+OCTET_W-1:0] sel_wide;
  logic [OCTET_W-1:0]       octet;
  logic                     mismatch;
  logic                     out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      address_base  <= ADDRESS_BASE_RST;
      offer_hold_ms <= OFFER_HOLD_RST;
      lease_time_ms <= LEASE_TIME_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_ADDRESS_BASE: address_base  <= cfg_data[OCTET_W-1:0];
        REG_OFFER_HOLD:   offer_hold_ms <= cfg_data;
        REG_LEASE_TIME:   lease_time_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  assign rd_en = (state == ST_SCAN) && (issue_cnt < CNT_W'(LEASE_SLOTS));

  always_comb begin
    diff_now  = rd_data.expiry - item_now;
    diff_old  = rd_data.expiry - oldest_exp;
    unused    = (rd_data.mac == '0);
    expired   = !unused && ((diff_now == '0) || diff_now[TIME_W-1]);
    hit       = (rd_data.mac == item_mac);
    free_here = unused || expired;
    have_free_upd = have_free || free_here;
    free_upd      = have_free ? free_slot : eval_idx;
    // slot zero seeds the earliest-expiry search
    if ((eval_idx == '0) || diff_old[TIME_W-1]) begin
      oldest_upd     = eval_idx;
      oldest_exp_upd = rd_data.expiry;
    end else begin
      oldest_upd     = oldest;
      oldest_exp_upd = oldest_exp;
    end
    last_eval = (eval_idx == IDX_W'(LEASE_SLOTS - 1));
  end

  always_comb begin
    sel_wide = {{OCTET_W{1'b0}}, sel};
    octet    = address_base + sel_wide[OCTET_W-1:0];
    mismatch = (item_action == ACT_REQUEST) && item_has_req && (item_req_octet != octet);
    wr_en    = (state == ST_DECIDE) && !mismatch;
    wr_data.mac    = item_mac;
    wr_data.expiry = item_now +
                     ((item_action == ACT_DISCOVER) ? offer_hold_ms : lease_time_ms);
  end

  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      m_tvalid   <= 1'b0;
      eval_valid <= 1'b0;
      issue_cnt  <= '0;
      have_free  <= 1'b0;
    end else begin
      if (m_tready && !((state == ST_RESULT) && out_free)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            item_action    <= s_tuser;
            item_mac       <= s_tdata[47:0];
            item_has_req   <= s_tdata[48];
            item_req_octet <= s_tdata[56:49];
            item_now       <= s_tdata[88:57];
            issue_cnt      <= '0;
            eval_valid     <= 1'b0;
            have_free      <= 1'b0;
            if ((s_tuser == ACT_DISCOVER) || (s_tuser == ACT_REQUEST)) begin
              state <= ST_SCAN;
            end else begin
              res_status <= REPLY_IGNORE;
              res_slot   <= '0;
              res_octet  <= '0;
              state      <= ST_RESULT;
            end
          end
        end
        ST_SCAN: begin
          if (rd_en) begin
            issue_cnt <= issue_cnt + CNT_W'(1);
          end
          // the scan stops on a hit or after the last slot
          eval_valid <= rd_en && !(eval_valid && (hit || last_eval));
          eval_idx   <= issue_cnt[IDX_W-1:0];
          if (eval_valid) begin
            have_free  <= have_free_upd;
            free_slot  <= free_upd;
            oldest     <= oldest_upd;
            oldest_exp <= oldest_exp_upd;
            if (hit) begin
              sel        <= eval_idx;
              state      <= ST_DECIDE;
            end else if (last_eval) begin
              sel        <= have_free_upd ? free_upd : oldest_upd;
              state      <= ST_DECIDE;
            end
          end
        end
        ST_DECIDE: begin
          if (mismatch) begin
            res_status <= REPLY_IGNORE;
            res_slot   <= '0;
            res_octet  <= '0;
          end else begin
            res_status <= (item_action == ACT_DISCOVER) ? REPLY_OFFER : REPLY_ACK;
            res_slot   <= sel_wide[SLOT_W-1:0];
            res_octet  <= octet;
          end
          state <= ST_RESULT;
        end
        ST_RESULT: begin
          if (out_free) begin
            m_tvalid   <= 1'b1;
            out_status <= res_status;
            out_slot   <= res_slot;
            out_octet  <= res_octet;
            state      <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign m_tuser = out_status;
  assign m_tdata = {{(M_TDATA_W - SLOT_W - OCTET_W){1'b0}}, out_octet, out_slot};

  dhcplt_lease_mem #(
    .SLOTS(LEASE_SLOTS)
  ) u_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (rd_en),
    .rd_addr (issue_cnt[IDX_W-1:0]),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (sel),
    .wr_data (wr_data)
  );

endmodule

`default_nettype wire

[dv/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
  import dhcplt_pkg::*;

  localparam int CLK_HALF     = 4;
  localparam int RESET_CYCLES = 8;
  localparam int DRAIN_CYCLES = 24;
  localparam int STALL_CYCLES = 400;
  localparam int MAC_POOL     = 12;

  // kinds the block must ignore
  localparam logic [ACTION_W-1:0] ACT_OTHER    = 2'd2;
  localparam logic [ACTION_W-1:0] ACT_RESERVED = 2'd3;
  // register index with no register behind it
  localparam logic [CFG_ADDR_W-1:0] REG_NONE = 2'd3;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [MAC_W-1:0]    mac;
    logic                has_req;
    logic [OCTET_W-1:0]  req_octet;
    logic [TIME_W-1:0]   now_ms;
  } msg_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
    logic [OCTET_W-1:0]  octet;
  } reply_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [S_TDATA_W-1:0]  s_tdata = '0;
  logic [ACTION_W-1:0]   s_tuser = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [M_TDATA_W-1:0]  m_tdata;
  logic [STATUS_W-1:0]   m_tuser;
  logic                  cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  dhcp_lease_table_engine dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data)
  );

  always #CLK_HALF clk = ~clk;

  // lease table mirror and register copies
  logic [MAC_W-1:0]   lease_mac [LEASE_SLOTS_DEF];
  logic [TIME_W-1:0]  lease_expiry [LEASE_SLOTS_DEF];
  logic [OCTET_W-1:0] cfg_base = ADDRESS_BASE_RST;
  logic [TIME_W-1:0]  cfg_hold = OFFER_HOLD_RST;
  logic [TIME_W-1:0]  cfg_lease = LEASE_TIME_RST;

  reply_t reply_q[$];
  reply_t want_reply;
  int     mismatch_count = 0;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int stall_req = 0;
  int stall_taken = 0;
  int stall_left = 0;

  logic [MAC_W-1:0]  mac_pool [MAC_POOL];
  logic [TIME_W-1:0] clock_ms;
  int                time_step_max = 100;

  initial begin
    for (int i = 0; i < LEASE_SLOTS_DEF; i++) begin
      lease_mac[i] = '0;
      lease_expiry[i] = '0;
    end
  end

  function automatic logic [SLOT_W-1:0] lease_pick(logic [MAC_W-1:0] mac,
                                                    logic [TIME_W-1:0] now_ms);
    int                oldest;
    int                free_slot;
    bit                have_free;
    bit                unused;
    bit                expired;
    logic [TIME_W-1:0] d;
    logic [TIME_W-1:0] d_old;
    oldest = 0;
    free_slot = 0;
    have_free = 1'b0;
    for (int i = 0; i < LEASE_SLOTS_DEF; i++) begin
      if (lease_mac[i] == mac) return SLOT_W'(i);
      unused = (lease_mac[i] == '0);
      d = lease_expiry[i] - now_ms;
      // expiry at or before now counts as expired
      expired = !unused && (d == '0 || d[TIME_W-1]);
      if (!have_free && (unused || expired)) begin
        have_free = 1'b1;
        free_slot = i;
      end
      d_old = lease_expiry[i] - lease_expiry[oldest];
      if (d_old[TIME_W-1]) oldest = i;
    end
    return have_free ? SLOT_W'(free_slot) : SLOT_W'(oldest);
  endfunction

  function automatic reply_t predict_reply(msg_t m);
    reply_t             r;
    logic [SLOT_W-1:0]  s;
    logic [OCTET_W-1:0] oct;
    r.status = REPLY_IGNORE;
    r.slot = '0;
    r.octet = '0;
    if (m.action != ACT_DISCOVER && m.action != ACT_REQUEST) return r;
    s = lease_pick(m.mac, m.now_ms);
    oct = cfg_base + OCTET_W'(s);
    if (m.action == ACT_REQUEST && m.has_req && m.req_octet != oct) return r;
    lease_mac[s] = m.mac;
    if (m.action == ACT_DISCOVER) begin
      lease_expiry[s] = m.now_ms + cfg_hold;
      r.status = REPLY_OFFER;
    end else begin
      lease_expiry[s] = m.now_ms + cfg_lease;
      r.status = REPLY_ACK;
    end
    r.slot = s;
    r.octet = oct;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    mismatch_count++;
    $display("[%0t] mismatch %s: got %0h, expected %0h", $realtime, what, got, want);
  endtask

  // called at a rising edge; returns at the edge where the item was taken
  task automatic send_msg(logic [ACTION_W-1:0] action, logic [MAC_W-1:0] mac,
                          logic has_req, logic [OCTET_W-1:0] req_octet,
                          logic [TIME_W-1:0] now_ms);
    msg_t m;
    m.action = action;
    m.mac = mac;
    m.has_req = has_req;
    m.req_octet = req_octet;
    m.now_ms = now_ms;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {7'b0, m.now_ms, m.req_octet, m.has_req, m.mac};
    s_tuser <= m.action;
    do @(posedge clk); while (!s_tready);
    reply_q.push_back(predict_reply(m));
  endtask

  task automatic wait_for_replies();
    s_tvalid <= 1'b0;
    while (reply_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_addr <= addr;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (addr)
      REG_ADDRESS_BASE: cfg_base = data[OCTET_W-1:0];
      REG_OFFER_HOLD:   cfg_hold = data;
      REG_LEASE_TIME:   cfg_lease = data;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_config(logic [CFG_DATA_W-1:0] base, logic [TIME_W-1:0] hold,
                            logic [TIME_W-1:0] lease);
    wait_for_replies();
    write_reg(REG_ADDRESS_BASE, base);
    write_reg(REG_OFFER_HOLD, hold);
    write_reg(REG_LEASE_TIME, lease);
  endtask

  function automatic msg_t make_random_msg();
    msg_t        m;
    int          pick;
    logic [63:0] w;
    pick = $urandom_range(0, 99);
    if (pick < 45) m.action = ACT_DISCOVER;
    else if (pick < 85) m.action = ACT_REQUEST;
    else if (pick < 95) m.action = ACT_OTHER;
    else m.action = ACT_RESERVED;
    w = {$urandom(), $urandom()};
    // slowly rotate the client population so evictions keep happening
    if ($urandom_range(0, 99) < 4) mac_pool[$urandom_range(0, MAC_POOL - 1)] = w[MAC_W-1:0];
    pick = $urandom_range(0, 99);
    if (pick < 85) m.mac = mac_pool[$urandom_range(0, MAC_POOL - 1)];
    else if (pick < 90) m.mac = '0;
    else m.mac = w[MAC_W-1:0];
    if ($urandom_range(0, 99) < 3) clock_ms = $urandom();
    else clock_ms = clock_ms + $urandom_range(0, time_step_max);
    m.now_ms = clock_ms;
    m.has_req = 1'($urandom_range(0, 1));
    // half the requested octets aim at the slot the client would get
    if ($urandom_range(0, 1)) m.req_octet = cfg_base + OCTET_W'(lease_pick(m.mac, m.now_ms));
    else m.req_octet = OCTET_W'($urandom_range(0, 255));
    return m;
  endfunction

  task automatic test_reset_defaults();
    send_idle_pct = 30;
    recv_idle_pct = 57;
    send_msg(ACT_DISCOVER, '1, 1'b0, 8'd0, 32'd1000);
    send_msg(ACT_REQUEST, '1, 1'b1, ADDRESS_BASE_RST, 32'd1100);
    // requested octet that does not belong to the chosen slot
    send_msg(ACT_REQUEST, 48'h1, 1'b1, 8'hFF, 32'd1200);
    send_msg(ACT_REQUEST, 48'h1, 1'b0, 8'd0, 32'd1300);
    send_msg(ACT_OTHER, '1, 1'b1, 8'hFF, 32'hFFFF_FFFF);
    send_msg(ACT_RESERVED, 48'h1, 1'b0, 8'd0, 32'd0);
    // all-zero mac lands on the first unused slot
    send_msg(ACT_DISCOVER, '0, 1'b0, 8'd0, 32'd1400);
  endtask

  task automatic test_directed_cases();
    logic [MAC_W-1:0] mac;
    set_config(CFG_DATA_W'(ADDRESS_BASE_RST), 32'd50, 32'd100);
    for (int k = 0; k < 6; k++)
      send_msg(ACT_DISCOVER, 48'h0A00_0000_0000 | MAC_W'(k + 1), 1'b0, 8'd0, 32'd2000);
    // table full, nothing expired: earliest expiry is taken
    send_msg(ACT_DISCOVER, 48'h0B00_0000_0001, 1'b0, 8'd0, 32'd2040);
    // expiry equal to now counts as expired
    send_msg(ACT_DISCOVER, 48'h0B00_0000_0002, 1'b0, 8'd0, 32'd2050);
    // upper data bits are dropped for the octet register; base + slot wraps
    set_config(32'hABCD_EFFF, 32'd50, 32'h0000_1000);
    mac = 48'h0C00_0000_0001;
    send_msg(ACT_REQUEST, mac, 1'b1, cfg_base + OCTET_W'(lease_pick(mac, 32'hFFFF_FF00)),
             32'hFFFF_FF00);
    mac = 48'h0C00_0000_0002;
    send_msg(ACT_REQUEST, mac, 1'b1,
             cfg_base + OCTET_W'(lease_pick(mac, 32'hFFFF_FFF0)) + 8'd1, 32'hFFFF_FFF0);
    send_msg(ACT_DISCOVER, 48'h0C00_0000_0001, 1'b0, 8'd0, 32'h0000_0010);
    wait_for_replies();
    write_reg(REG_NONE, 32'h5555_5555);
    send_msg(ACT_REQUEST, 48'h8000_0000_0000, 1'b0, 8'd0, 32'h0000_0020);
  endtask

  task automatic test_random_traffic(int n_items, int send_pct, int recv_pct, int step_max);
    msg_t m;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    time_step_max = step_max;
    for (int k = 0; k < n_items; k++) begin
      // long output stall while input keeps coming
      if (k == n_items / 3) stall_req++;
      // let the block run dry in the middle of the phase
      if (k == 2 * n_items / 3) wait_for_replies();
      m = make_random_msg();
      send_msg(m.action, m.mac, m.has_req, m.req_octet, m.now_ms);
    end
    wait_for_replies();
  endtask

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left = stall_left - 1;
      m_tready <= 1'b0;
    end else if (stall_req != stall_taken) begin
      stall_taken = stall_req;
      stall_left = STALL_CYCLES;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (reply_q.size() == 0) begin
        report_mismatch("reply with no item pending", 64'({m_tuser, m_tdata}), 64'd0);
      end else begin
        want_reply = reply_q.pop_front();
        if (m_tuser != want_reply.status)
          report_mismatch("reply_status", 64'(m_tuser), 64'(want_reply.status));
        if (m_tdata[2:0] != want_reply.slot)
          report_mismatch("slot_index", 64'(m_tdata[2:0]), 64'(want_reply.slot));
        if (m_tdata[10:3] != want_reply.octet)
          report_mismatch("offered_octet", 64'(m_tdata[10:3]), 64'(want_reply.octet));
      end
    end
  end

  initial begin
    for (int i = 0; i < MAC_POOL; i++) mac_pool[i] = MAC_W'({$urandom(), $urandom()});
    clock_ms = $urandom();
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_directed_cases();
    set_config($urandom_range(0, 248), $urandom_range(200, 800), $urandom_range(1000, 4000));
    test_random_traffic(400, 30, 57, 150);
    set_config(32'd0, 32'd0, 32'hFFFF_FFFF);
    test_random_traffic(400, 57, 30, 2);
    set_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
    test_random_traffic(300, 0, 0, 1000);
    set_config(CFG_DATA_W'(ADDRESS_BASE_RST), OFFER_HOLD_RST, LEASE_TIME_RST);
    test_random_traffic(300, 0, 0, 20000);
    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/dhcplt_pkg.sv
hw/rtl/dhcplt_lease_mem.sv
hw/rtl/dhcp_lease_table_engine.sv
dv/tb_top.sv
